// ===== rtl/clpt_pkg.sv =====
`default_nettype none

package clpt_pkg;

    localparam int DEF_FRAC_BITS = 32;
    localparam int WORD_W        = 64;
    localparam int WIDE_W        = 2 * WORD_W;
    localparam int FEE_W         = 20;
    localparam int CFG_IDX_W     = 3;

    localparam logic [WORD_W-1:0] PPM_SCALE = 64'd1000000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER    = 3'd0,
        CFG_UPPER    = 3'd1,
        CFG_START0   = 3'd2,
        CFG_START1   = 3'd3,
        CFG_FEE_RATE = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CSQRT,
        S_DISPATCH,
        S_SQRTP,
        S_FIRST,
        S_F_SASB,
        S_F_SPSB,
        S_F_MUL0,
        S_F_DIVW,
        S_F_DIV1,
        S_F_DIVX,
        S_F_DIVY,
        S_AMT,
        S_A_LW,
        S_A_SASB,
        S_A_LX,
        S_A_SPSB,
        S_A_DIV,
        S_A_LY,
        S_FEE,
        S_FEE_VP,
        S_FEE_T,
        S_FEE_Q,
        S_FEE_M,
        S_V_X,
        S_V_Y,
        S_V_H0,
        S_V_H1,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        op_t               op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WIDE_W-1:0] num;
    } arith_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] res;
        logic [WIDE_W-1:0] prod;
    } arith_rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] lower;
        logic [WORD_W-1:0] upper;
        logic [WORD_W-1:0] start0;
        logic [WORD_W-1:0] start1;
        logic [FEE_W-1:0]  fee_rate;
    } cfg_t;

    typedef struct packed {
        logic [WORD_W-1:0] liq;
        logic [WORD_W-1:0] tok0;
        logic [WORD_W-1:0] tok1;
        logic [WORD_W-1:0] fees;
        logic [WORD_W-1:0] loss;
        logic              in_band;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/clpt_arith.sv =====
`default_nettype none

// Shared bit-serial unit: shift-add multiply (64 steps), restoring divide
// (128 steps) and digit-by-digit square root (64 steps, two radicand bits each).
module clpt_arith #(
    parameter int FRAC_BITS = clpt_pkg::DEF_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire clpt_pkg::arith_req_t req,
    output clpt_pkg::arith_rsp_t      rsp
);
    import clpt_pkg::*;

    localparam int CNT_W = 7;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    op_t               op_reg, op_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W:0]   acc_reg, acc_next;
    logic [WIDE_W-1:0] n_reg, n_next;
    logic [WORD_W-1:0] d_reg, d_next;
    logic [WORD_W-1:0] root_reg, root_next;

    logic [WORD_W:0]   mul_sum;
    logic [WORD_W:0]   div_sh;
    logic [WORD_W:0]   div_diff;
    logic              div_ge;
    logic [WORD_W+2:0] sq_rem;
    logic [WORD_W+2:0] sq_trial;
    logic [WORD_W+2:0] sq_diff;
    logic              sq_ge;
    logic [WIDE_W-1:0] prod;

    assign mul_sum  = {1'b0, acc_reg[WORD_W-1:0]} + (n_reg[0] ? {1'b0, d_reg} : '0);
    assign div_sh   = {acc_reg[WORD_W-1:0], n_reg[WIDE_W-1]};
    assign div_ge   = div_sh >= {1'b0, d_reg};
    assign div_diff = div_sh - {1'b0, d_reg};
    assign sq_rem   = {acc_reg, n_reg[WIDE_W-1:WIDE_W-2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_rem >= sq_trial;
    assign sq_diff  = sq_rem - sq_trial;
    assign prod     = {acc_reg[WORD_W-1:0], n_reg[WORD_W-1:0]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        root_next = root_reg;
        if (!busy_reg) begin
            if (req.start) begin
                busy_next = 1'b1;
                op_next   = req.op;
                acc_next  = '0;
                root_next = '0;
                case (req.op)
                    OP_MUL: begin
                        n_next   = {{WORD_W{1'b0}}, req.b};
                        d_next   = req.a;
                        cnt_next = CNT_W'(WORD_W - 1);
                    end
                    OP_DIV: begin
                        n_next   = req.num;
                        d_next   = req.b;
                        cnt_next = CNT_W'(WIDE_W - 1);
                    end
                    default: begin
                        n_next   = req.num;
                        cnt_next = CNT_W'(WORD_W - 1);
                    end
                endcase
            end
        end else begin
            case (op_reg)
                OP_MUL: begin
                    acc_next = {1'b0, mul_sum[WORD_W:1]};
                    n_next   = {n_reg[WIDE_W-1:WORD_W], mul_sum[0], n_reg[WORD_W-1:1]};
                end
                OP_DIV: begin
                    if (div_ge) begin
                        acc_next = div_diff;
                        n_next   = {n_reg[WIDE_W-2:0], 1'b1};
                    end else begin
                        acc_next = div_sh;
                        n_next   = {n_reg[WIDE_W-2:0], 1'b0};
                    end
                end
                default: begin
                    if (sq_ge) begin
                        acc_next  = sq_diff[WORD_W:0];
                        root_next = {root_reg[WORD_W-2:0], 1'b1};
                    end else begin
                        acc_next  = sq_rem[WORD_W:0];
                        root_next = {root_reg[WORD_W-2:0], 1'b0};
                    end
                    n_next = {n_reg[WIDE_W-3:0], 2'b00};
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg  <= acc_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        root_reg <= root_next;
    end

    // Results saturate to all ones when they do not fit in one word.
    always_comb begin
        rsp.done = done_reg;
        rsp.prod = prod;
        case (op_reg)
            OP_MUL:  rsp.res = (|prod[WIDE_W-1:WORD_W+FRAC_BITS]) ? '1
                               : prod[WORD_W+FRAC_BITS-1:FRAC_BITS];
            OP_DIV:  rsp.res = (|n_reg[WIDE_W-1:WORD_W]) ? '1 : n_reg[WORD_W-1:0];
            OP_SQRT: rsp.res = root_reg;
            default: rsp.res = '0;
        endcase
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("operation started on a busy unit");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> ($past(busy_reg) && !busy_reg)) else $error("stray done pulse");

endmodule

`default_nettype wire

// ===== rtl/clpt_ctrl.sv =====
`default_nettype none

// Sequencer: roots each written range bound and walks the per-sample program,
// at most one operation of the shared unit per state; keeps the path state and the intermediate words.
module clpt_ctrl #(
    parameter int FRAC_BITS = clpt_pkg::DEF_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire clpt_pkg::cfg_t       cfg,
    input  wire logic                 cfg_wr,
    input  wire logic [2:0]           cfg_idx,
    input  wire logic [63:0]          cfg_value,
    input  wire logic                 s_fire,
    input  wire logic                 first_of_path,
    input  wire logic [63:0]          price,
    input  wire logic [63:0]          pool_liquidity,
    input  wire logic [63:0]          volume_usd,
    input  wire logic [63:0]          token0_usd,
    input  wire logic [63:0]          token1_usd,
    output logic                      idle,
    input  wire logic                 out_free,
    output logic                      res_valid,
    output clpt_pkg::result_t         res,
    output clpt_pkg::arith_req_t      req,
    input  wire clpt_pkg::arith_rsp_t rsp
);
    import clpt_pkg::*;

    localparam logic [WORD_W-1:0] INT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] INT_MIN_MAG = {1'b1, {(WORD_W-1){1'b0}}};

    function automatic logic [WORD_W-1:0] sub_sat(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    function automatic logic [WORD_W-1:0] add_sat(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? '1 : s[WORD_W-1:0];
    endfunction

    function automatic logic [WIDE_W-1:0] q_num(input logic [WORD_W-1:0] a);
        logic [WIDE_W-1:0] t;
        t = {{WORD_W{1'b0}}, a};
        return t << FRAC_BITS;
    endfunction

    state_t            state_reg, state_next;
    logic              go_reg, go_next;
    logic              csel_reg, csel_next;
    logic              first_reg, first_next;
    logic [WORD_W-1:0] price_reg, price_next;
    logic [WORD_W-1:0] pool_reg, pool_next;
    logic [WORD_W-1:0] vol_reg, vol_next;
    logic [WORD_W-1:0] t0_reg, t0_next;
    logic [WORD_W-1:0] t1_reg, t1_next;
    logic [WORD_W-1:0] sa_reg, sa_next;
    logic [WORD_W-1:0] sb_reg, sb_next;
    logic [WORD_W-1:0] sp_reg, sp_next;
    logic [WORD_W-1:0] l_reg, l_next;
    logic [WORD_W-1:0] fee_reg, fee_next;
    logic [WORD_W-1:0] ta_reg, ta_next;
    logic [WORD_W-1:0] tb_reg, tb_next;
    logic [WORD_W-1:0] x_reg, x_next;
    logic [WORD_W-1:0] y_reg, y_next;
    logic [WIDE_W-1:0] p_reg, p_next;
    logic [WORD_W-1:0] lp_reg, lp_next;
    logic [WORD_W-1:0] hold_reg, hold_next;

    logic              le, ge, mid;
    logic [WORD_W-1:0] w, sbp, spa;
    logic              need_op;
    logic              done;
    logic [WORD_W-1:0] r;

    assign le   = price_reg <= cfg.lower;
    assign ge   = !le && (price_reg >= cfg.upper);
    assign mid  = !le && !ge;
    assign w    = sub_sat(sb_reg, sa_reg);
    assign sbp  = sub_sat(sb_reg, sp_reg);
    assign spa  = sub_sat(sp_reg, sa_reg);
    assign done = rsp.done;
    assign r    = rsp.res;
    assign idle = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        go_next    = go_reg;
        csel_next  = csel_reg;
        first_next = first_reg;
        price_next = price_reg;
        pool_next  = pool_reg;
        vol_next   = vol_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        sp_next    = sp_reg;
        l_next     = l_reg;
        fee_next   = fee_reg;
        ta_next    = ta_reg;
        tb_next    = tb_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        p_next     = p_reg;
        lp_next    = lp_reg;
        hold_next  = hold_reg;
        need_op    = 1'b0;
        res_valid  = 1'b0;
        req.op     = OP_MUL;
        req.a      = '0;
        req.b      = '0;
        req.num    = '0;

        case (state_reg)
            S_IDLE: begin
                if (cfg_wr && (cfg_idx == CFG_LOWER || cfg_idx == CFG_UPPER)) begin
                    csel_next  = (cfg_idx == CFG_UPPER);
                    ta_next    = cfg_value;
                    state_next = S_CSQRT;
                end else if (s_fire) begin
                    first_next = first_of_path;
                    price_next = price;
                    pool_next  = pool_liquidity;
                    vol_next   = volume_usd;
                    t0_next    = token0_usd;
                    t1_next    = token1_usd;
                    state_next = S_DISPATCH;
                end
            end
            S_CSQRT: begin
                need_op = 1'b1;
                req.op  = OP_SQRT;
                req.num = q_num(ta_reg);
                if (done) begin
                    if (csel_reg) sb_next = r;
                    else sa_next = r;
                    state_next = S_IDLE;
                end
            end
            S_DISPATCH: state_next = mid ? S_SQRTP : S_FIRST;
            S_SQRTP: begin
                need_op = 1'b1;
                req.op  = OP_SQRT;
                req.num = q_num(price_reg);
                if (done) begin
                    sp_next    = r;
                    state_next = S_FIRST;
                end
            end
            S_FIRST: begin
                if (first_reg) begin
                    fee_next = '0;
                    if (le) state_next = S_F_SASB;
                    else if (ge) state_next = S_F_DIV1;
                    else state_next = S_F_SPSB;
                end else begin
                    state_next = S_AMT;
                end
            end
            S_F_SASB: begin
                need_op = 1'b1;
                req.a   = sa_reg;
                req.b   = sb_reg;
                if (done) begin
                    ta_next    = r;
                    state_next = S_F_MUL0;
                end
            end
            S_F_SPSB: begin
                need_op = 1'b1;
                req.a   = sp_reg;
                req.b   = sb_reg;
                if (done) begin
                    ta_next    = r;
                    state_next = S_F_MUL0;
                end
            end
            S_F_MUL0: begin
                need_op = 1'b1;
                req.a   = cfg.start0;
                req.b   = ta_reg;
                if (done) begin
                    tb_next    = r;
                    state_next = le ? S_F_DIVW : S_F_DIVX;
                end
            end
            S_F_DIVW: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = q_num(tb_reg);
                req.b   = w;
                if (done) begin
                    l_next     = r;
                    state_next = S_AMT;
                end
            end
            S_F_DIV1: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = q_num(cfg.start1);
                req.b   = w;
                if (done) begin
                    l_next     = r;
                    state_next = S_AMT;
                end
            end
            S_F_DIVX: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = q_num(tb_reg);
                req.b   = sbp;
                if (done) begin
                    ta_next    = r;
                    state_next = S_F_DIVY;
                end
            end
            S_F_DIVY: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = q_num(cfg.start1);
                req.b   = spa;
                if (done) begin
                    // The tighter of the two token bounds sets the liquidity.
                    l_next     = (r < ta_reg) ? r : ta_reg;
                    state_next = S_AMT;
                end
            end
            S_AMT: state_next = mid ? S_A_LX : S_A_LW;
            S_A_LW: begin
                need_op = 1'b1;
                req.a   = l_reg;
                req.b   = w;
                if (done) begin
                    if (le) begin
                        ta_next    = r;
                        state_next = S_A_SASB;
                    end else begin
                        x_next     = '0;
                        y_next     = r;
                        state_next = S_FEE;
                    end
                end
            end
            S_A_SASB: begin
                need_op = 1'b1;
                req.a   = sa_reg;
                req.b   = sb_reg;
                if (done) begin
                    tb_next    = r;
                    state_next = S_A_DIV;
                end
            end
            S_A_LX: begin
                need_op = 1'b1;
                req.a   = l_reg;
                req.b   = sbp;
                if (done) begin
                    ta_next    = r;
                    state_next = S_A_SPSB;
                end
            end
            S_A_SPSB: begin
                need_op = 1'b1;
                req.a   = sp_reg;
                req.b   = sb_reg;
                if (done) begin
                    tb_next    = r;
                    state_next = S_A_DIV;
                end
            end
            S_A_DIV: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = q_num(ta_reg);
                req.b   = tb_reg;
                if (done) begin
                    x_next = r;
                    if (le) begin
                        y_next     = '0;
                        state_next = S_FEE;
                    end else begin
                        state_next = S_A_LY;
                    end
                end
            end
            S_A_LY: begin
                need_op = 1'b1;
                req.a   = l_reg;
                req.b   = spa;
                if (done) begin
                    y_next     = r;
                    state_next = S_FEE;
                end
            end
            S_FEE: state_next = (mid && pool_reg != '0) ? S_FEE_VP : S_V_X;
            S_FEE_VP: begin
                // Full-width product: the ppm scale is an integer, not fixed point.
                need_op = 1'b1;
                req.a   = vol_reg;
                req.b   = {{(WORD_W-FEE_W){1'b0}}, cfg.fee_rate};
                if (done) begin
                    p_next     = rsp.prod;
                    state_next = S_FEE_T;
                end
            end
            S_FEE_T: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = p_reg;
                req.b   = PPM_SCALE;
                if (done) begin
                    ta_next    = r;
                    state_next = S_FEE_Q;
                end
            end
            S_FEE_Q: begin
                need_op = 1'b1;
                req.op  = OP_DIV;
                req.num = q_num(l_reg);
                req.b   = pool_reg;
                if (done) begin
                    tb_next    = r;
                    state_next = S_FEE_M;
                end
            end
            S_FEE_M: begin
                need_op = 1'b1;
                req.a   = ta_reg;
                req.b   = tb_reg;
                if (done) begin
                    fee_next   = add_sat(fee_reg, r);
                    state_next = S_V_X;
                end
            end
            S_V_X: begin
                need_op = 1'b1;
                req.a   = x_reg;
                req.b   = t0_reg;
                if (done) begin
                    ta_next    = r;
                    state_next = S_V_Y;
                end
            end
            S_V_Y: begin
                need_op = 1'b1;
                req.a   = y_reg;
                req.b   = t1_reg;
                if (done) begin
                    lp_next    = add_sat(ta_reg, r);
                    state_next = S_V_H0;
                end
            end
            S_V_H0: begin
                need_op = 1'b1;
                req.a   = cfg.start0;
                req.b   = t0_reg;
                if (done) begin
                    ta_next    = r;
                    state_next = S_V_H1;
                end
            end
            S_V_H1: begin
                need_op = 1'b1;
                req.a   = cfg.start1;
                req.b   = t1_reg;
                if (done) begin
                    hold_next  = add_sat(ta_reg, r);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        req.start = need_op && !go_reg;
        if (req.start) go_next = 1'b1;
        if (done) go_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            sa_reg    <= '0;
            sb_reg    <= '0;
            l_reg     <= '0;
            fee_reg   <= '0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
            l_reg     <= l_next;
            fee_reg   <= fee_next;
        end
        csel_reg  <= csel_next;
        first_reg <= first_next;
        price_reg <= price_next;
        pool_reg  <= pool_next;
        vol_reg   <= vol_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        sp_reg    <= sp_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        p_reg     <= p_next;
        lp_reg    <= lp_next;
        hold_reg  <= hold_next;
    end

    // Position value minus hold value, clamped to the signed word range.
    always_comb begin
        res.liq      = l_reg;
        res.tok0     = x_reg;
        res.tok1     = y_reg;
        res.fees     = fee_reg;
        res.in_band  = mid;
        if (lp_reg >= hold_reg) begin
            res.loss = ((lp_reg - hold_reg) > INT_MAX) ? INT_MAX : (lp_reg - hold_reg);
        end else if ((hold_reg - lp_reg) > INT_MIN_MAG) begin
            res.loss = INT_MIN_MAG;
        end else begin
            res.loss = '0 - (hold_reg - lp_reg);
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free) else $error("result issued into a full output stage");
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> go_reg) else $error("unit finished an operation never issued");

endmodule

`default_nettype wire

// ===== rtl/concentrated_liquidity_position_tracker.sv =====
`default_nettype none

// Channel   Direction  Handshake              Word
// s_        in         s_valid / s_ready      one price sample
// m_        out        m_valid / m_ready      one position result per sample
// cfg_      in         cfg_valid / cfg_ready  register index and data
//
// Every multiply, divide and square root runs one bit per cycle on a single
// shared unit, and the longest path is a path start inside the range.
// Writing a range bound runs its square root on the same shared unit.
// Reset is synchronous and active low; it clears the liquidity, fee sum and roots.
// The output register frees the core: the next sample is computed while a
// result waits, and the core stalls only when that finished result is not taken.
module concentrated_liquidity_position_tracker #(
    parameter int FRAC_BITS = clpt_pkg::DEF_FRAC_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_first_of_path,
    input  wire logic [63:0] s_price,
    input  wire logic [63:0] s_pool_liquidity,
    input  wire logic [63:0] s_volume_usd,
    input  wire logic [63:0] s_token0_usd,
    input  wire logic [63:0] s_token1_usd,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_position_liquidity_out,
    output logic [63:0]      m_token0_amount,
    output logic [63:0]      m_token1_amount,
    output logic [63:0]      m_fees_accumulated,
    output logic signed [63:0] m_loss_vs_hold,
    output logic             m_in_range,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import clpt_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    result_t    out_reg;
    logic       m_valid_reg, m_valid_next;
    logic       idle;
    logic       out_free;
    logic       res_valid;
    logic       cfg_wr;
    logic       s_fire;
    result_t    res;
    arith_req_t req;
    arith_rsp_t rsp;

    // The sequencer takes configuration only while idle; a pending
    // configuration word holds samples back for that cycle.
    assign cfg_ready = idle;
    assign s_ready   = idle && !cfg_valid;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (cfg_index)
                CFG_LOWER:    cfg_next.lower    = cfg_data;
                CFG_UPPER:    cfg_next.upper    = cfg_data;
                CFG_START0:   cfg_next.start0   = cfg_data;
                CFG_START1:   cfg_next.start1   = cfg_data;
                CFG_FEE_RATE: cfg_next.fee_rate = cfg_data[FEE_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
        m_valid_next = m_valid_reg;
        if (res_valid) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower    <= '0;
            cfg_reg.upper    <= '0;
            cfg_reg.start0   <= '0;
            cfg_reg.start1   <= '0;
            cfg_reg.fee_rate <= FEE_W'(3000);
            m_valid_reg      <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        if (res_valid) out_reg <= res;
    end

    clpt_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .cfg_wr         (cfg_wr),
        .cfg_idx        (cfg_index),
        .cfg_value      (cfg_data),
        .s_fire         (s_fire),
        .first_of_path  (s_first_of_path),
        .price          (s_price),
        .pool_liquidity (s_pool_liquidity),
        .volume_usd     (s_volume_usd),
        .token0_usd     (s_token0_usd),
        .token1_usd     (s_token1_usd),
        .idle           (idle),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .res            (res),
        .req            (req),
        .rsp            (rsp)
    );

    clpt_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    assign m_valid                  = m_valid_reg;
    assign m_position_liquidity_out = out_reg.liq;
    assign m_token0_amount          = out_reg.tok0;
    assign m_token1_amount          = out_reg.tok1;
    assign m_fees_accumulated       = out_reg.fees;
    assign m_loss_vs_hold           = out_reg.loss;
    assign m_in_range               = out_reg.in_band;

    a_one_port: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> !cfg_wr) else $error("sample and configuration taken together");

endmodule

`default_nettype wire

// ===== verif/concentrated_liquidity_position_tracker_tb.sv =====
`timescale 1ns / 100ps

module concentrated_liquidity_position_tracker_tb;
    import clpt_pkg::*;

    localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_Q = 64'd1 << 32;

    // One price sample as it is offered on the input channel.
    typedef struct {
        logic        first;
        logic [63:0] price;
        logic [63:0] pool;
        logic [63:0] volume;
        logic [63:0] usd0;
        logic [63:0] usd1;
    } sample_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_first_of_path;
    logic [63:0] s_price;
    logic [63:0] s_pool_liquidity;
    logic [63:0] s_volume_usd;
    logic [63:0] s_token0_usd;
    logic [63:0] s_token1_usd;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_position_liquidity_out;
    logic [63:0] m_token0_amount;
    logic [63:0] m_token1_amount;
    logic [63:0] m_fees_accumulated;
    logic signed [63:0] m_loss_vs_hold;
    logic        m_in_range;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    concentrated_liquidity_position_tracker u_top (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .s_valid                  (s_valid),
        .s_ready                  (s_ready),
        .s_first_of_path          (s_first_of_path),
        .s_price                  (s_price),
        .s_pool_liquidity         (s_pool_liquidity),
        .s_volume_usd             (s_volume_usd),
        .s_token0_usd             (s_token0_usd),
        .s_token1_usd             (s_token1_usd),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_position_liquidity_out (m_position_liquidity_out),
        .m_token0_amount          (m_token0_amount),
        .m_token1_amount          (m_token1_amount),
        .m_fees_accumulated       (m_fees_accumulated),
        .m_loss_vs_hold           (m_loss_vs_hold),
        .m_in_range               (m_in_range),
        .cfg_valid                (cfg_valid),
        .cfg_ready                (cfg_ready),
        .cfg_index                (cfg_index),
        .cfg_data                 (cfg_data)
    );

    // Free-running clock with a 10 ns period.
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Shadow copy of the position state and the registers, updated as words are accepted.
    logic [63:0] pos_lower, pos_upper, pos_start0, pos_start1;
    logic [19:0] pos_fee_rate;
    logic [63:0] pos_liq, pos_fees, root_lower, root_upper;

    sample_t sample_q[$];
    result_t position_q[$];
    sample_t cur_sample;
    bit      sample_taken;
    int      s_gap;
    int      m_gap;
    bit      no_idle;
    int      mismatch_count;

    function automatic logic [63:0] clamp64(logic [127:0] v);
        return (v[127:64] != 0) ? MAX64 : v[63:0];
    endfunction

    // Fixed-point multiply, divide and square root on 128-bit intermediates.
    function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return clamp64(p >> 32);
    endfunction

    function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
        logic [127:0] n;
        if (b == 0) return MAX64;
        n = {64'd0, a} << 32;
        return clamp64(n / {64'd0, b});
    endfunction

    function automatic logic [63:0] fx_root(logic [63:0] a);
        logic [127:0] n;
        logic [63:0]  r;
        logic [63:0]  c;
        n = {64'd0, a} << 32;
        r = 0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] floor_sub(logic [63:0] a, logic [63:0] b);
        return (a > b) ? a - b : 64'd0;
    endfunction

    function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? MAX64 : s[63:0];
    endfunction

    // Liquidity fixed at the start of a path; outside the range only one side bounds it.
    function automatic logic [63:0] path_liquidity(logic [63:0] price);
        logic [63:0] width, sp, lx, ly;
        width = floor_sub(root_upper, root_lower);
        if (price <= pos_lower)
            return fx_div(fx_mul(pos_start0, fx_mul(root_lower, root_upper)), width);
        if (price >= pos_upper)
            return fx_div(pos_start1, width);
        sp = fx_root(price);
        lx = fx_div(fx_mul(pos_start0, fx_mul(sp, root_upper)), floor_sub(root_upper, sp));
        ly = fx_div(pos_start1, floor_sub(sp, root_lower));
        return (lx < ly) ? lx : ly;
    endfunction

    // Advances the shadow state by one sample and returns the result it must produce.
    function automatic result_t predict_position(sample_t smp);
        result_t      r;
        logic [63:0]  width, sp, x, y, t, lp, hold, d;
        logic [127:0] vp;
        bit           price_in_band;
        width = floor_sub(root_upper, root_lower);
        if (smp.first) begin
            pos_liq  = path_liquidity(smp.price);
            pos_fees = 0;
        end
        price_in_band = (smp.price > pos_lower) && (smp.price < pos_upper);
        if (smp.price <= pos_lower) begin
            x = fx_div(fx_mul(pos_liq, width), fx_mul(root_lower, root_upper));
            y = 0;
        end else if (smp.price >= pos_upper) begin
            x = 0;
            y = fx_mul(pos_liq, width);
        end else begin
            sp = fx_root(smp.price);
            x  = fx_div(fx_mul(pos_liq, floor_sub(root_upper, sp)), fx_mul(sp, root_upper));
            y  = fx_mul(pos_liq, floor_sub(sp, root_lower));
        end
        // Zero pool liquidity earns no fee.
        if (price_in_band && smp.pool != 0) begin
            vp = {64'd0, smp.volume} * {108'd0, pos_fee_rate};
            t  = clamp64(vp / 128'd1000000);
            pos_fees = clamp_add(pos_fees, fx_mul(t, fx_div(pos_liq, smp.pool)));
        end
        lp   = clamp_add(fx_mul(x, smp.usd0), fx_mul(y, smp.usd1));
        hold = clamp_add(fx_mul(pos_start0, smp.usd0), fx_mul(pos_start1, smp.usd1));
        if (lp >= hold) begin
            d = lp - hold;
            r.loss = (d > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : d;
        end else begin
            d = hold - lp;
            if (d > 64'h8000_0000_0000_0000) d = 64'h8000_0000_0000_0000;
            r.loss = 64'd0 - d;
        end
        r.liq      = pos_liq;
        r.tok0     = x;
        r.tok1     = y;
        r.fees     = pos_fees;
        r.in_band  = price_in_band;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Input side: a word accepted at this edge is predicted right away, since the
    // registers only change while the block is drained.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            position_q.push_back(predict_position(cur_sample));
            sample_taken = 1;
        end
    end

    // Output side: each result word is checked against the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (position_q.size() == 0) begin
                report_mismatch("unexpected result, liquidity", m_position_liquidity_out, 0);
            end else begin
                want = position_q.pop_front();
                if (m_position_liquidity_out !== want.liq)
                    report_mismatch("position liquidity", m_position_liquidity_out, want.liq);
                if (m_token0_amount !== want.tok0)
                    report_mismatch("token0 amount", m_token0_amount, want.tok0);
                if (m_token1_amount !== want.tok1)
                    report_mismatch("token1 amount", m_token1_amount, want.tok1);
                if (m_fees_accumulated !== want.fees)
                    report_mismatch("fee sum", m_fees_accumulated, want.fees);
                if (m_loss_vs_hold !== want.loss)
                    report_mismatch("loss vs hold", m_loss_vs_hold, want.loss);
                if (m_in_range !== want.in_band)
                    report_mismatch("in range", {63'd0, m_in_range}, {63'd0, want.in_band});
            end
        end
    end

    // Driver and receiver: inputs move on the falling edge, with random idle bursts
    // on both sides until the quiet tail of the run.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || sample_taken)) begin
            sample_taken = 0;
            if (s_gap > 0) begin
                s_gap--;
                s_valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                cur_sample = sample_q.pop_front();
                s_first_of_path  <= cur_sample.first;
                s_price          <= cur_sample.price;
                s_pool_liquidity <= cur_sample.pool;
                s_volume_usd     <= cur_sample.volume;
                s_token0_usd     <= cur_sample.usd0;
                s_token1_usd     <= cur_sample.usd1;
                s_valid          <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
        if (aresetn) begin
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 7) == 0) m_gap = $urandom_range(1, 6);
            end
        end
    end

    // A value of mixed magnitude: zero, full scale, whole random, below sixteen, below one, shifted down.
    function automatic logic [63:0] any_word();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return MAX64;
            2: return {$urandom, $urandom};
            3: return ({32'd0, $urandom_range(0, 15)} << 32) + {32'd0, $urandom};
            4: return {32'd0, $urandom};
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Moderate values keep the dollar sums out of saturation most of the time.
    function automatic logic [63:0] mid_word();
        return ({32'd0, $urandom_range(0, 1000)} << 32) + {32'd0, $urandom};
    endfunction

    // Prices cluster on and inside the range so all three amount cases occur.
    function automatic logic [63:0] path_price();
        case ($urandom_range(0, 7))
            0: return pos_lower;
            1: return pos_upper;
            2: return any_word();
            default: begin
                if (pos_upper > pos_lower + 1)
                    return pos_lower + 1 + ({$urandom, $urandom} % (pos_upper - pos_lower - 1));
                return any_word();
            end
        endcase
    endfunction

    function automatic sample_t make_sample(logic first, logic [63:0] price,
                                            logic [63:0] pool, logic [63:0] volume,
                                            logic [63:0] usd0, logic [63:0] usd1);
        sample_t smp;
        smp.first  = first;
        smp.price  = price;
        smp.pool   = pool;
        smp.volume = volume;
        smp.usd0   = usd0;
        smp.usd1   = usd1;
        return smp;
    endfunction

    task automatic queue_path_samples(int count, bit open_path);
        sample_t smp;
        for (int i = 0; i < count; i++) begin
            smp.first  = (i == 0) ? open_path : ($urandom_range(0, 11) == 0);
            smp.price  = path_price();
            smp.pool   = ($urandom_range(0, 9) == 0) ? 64'd0 :
                         (($urandom_range(0, 3) == 0) ? any_word() : mid_word());
            smp.volume = ($urandom_range(0, 3) == 0) ? any_word() : mid_word();
            smp.usd0   = ($urandom_range(0, 5) == 0) ? any_word() : mid_word();
            smp.usd1   = ($urandom_range(0, 5) == 0) ? any_word() : mid_word();
            sample_q.push_back(smp);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (sample_q.size() != 0 || s_valid || position_q.size() != 0);
        repeat (40) @(posedge aclk);
    endtask

    // Register writes go out only while the block is drained; the shadow copy
    // follows each word as it is accepted.
    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_LOWER: begin
                pos_lower  = value;
                root_lower = fx_root(value);
            end
            CFG_UPPER: begin
                pos_upper  = value;
                root_upper = fx_root(value);
            end
            CFG_START0:   pos_start0   = value;
            CFG_START1:   pos_start1   = value;
            CFG_FEE_RATE: pos_fee_rate = value[19:0];
            default: ;
        endcase
    endtask

    task automatic set_position(logic [63:0] lower, logic [63:0] upper, logic [63:0] start0,
                                logic [63:0] start1, logic [63:0] fee);
        write_reg(CFG_LOWER, lower);
        write_reg(CFG_UPPER, upper);
        write_reg(CFG_START0, start0);
        write_reg(CFG_START1, start1);
        write_reg(CFG_FEE_RATE, fee);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [63:0] lo;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_first_of_path  = 1'b0;
        s_price          = 0;
        s_pool_liquidity = 0;
        s_volume_usd     = 0;
        s_token0_usd     = 0;
        s_token1_usd     = 0;
        m_ready          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_LOWER;
        cfg_data         = 0;
        sample_taken     = 0;
        s_gap            = 0;
        m_gap            = 0;
        no_idle          = 0;
        mismatch_count   = 0;
        pos_lower        = 0;
        pos_upper        = 0;
        pos_start0       = 0;
        pos_start1       = 0;
        pos_fee_rate     = 20'd3000;
        pos_liq          = 0;
        pos_fees         = 0;
        root_lower       = 0;
        root_upper       = 0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Samples before any path has started run on zero liquidity and reset registers.
        sample_q.push_back(make_sample(0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, MAX64, MAX64, MAX64, MAX64, MAX64));
        wait_drained();

        // Directed: range 1..4, ten of each token, default fee rate.
        set_position(ONE_Q, 4 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q, 3000);
        sample_q.push_back(make_sample(1, 2 * ONE_Q, 100 * ONE_Q, 1000 * ONE_Q, 2 * ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 3 * ONE_Q, 50 * ONE_Q, 500 * ONE_Q, 3 * ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, ONE_Q, 50 * ONE_Q, 500 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 4 * ONE_Q, 50 * ONE_Q, 500 * ONE_Q, 4 * ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 0, 50 * ONE_Q, 500 * ONE_Q, 0, ONE_Q));
        sample_q.push_back(make_sample(0, MAX64, 50 * ONE_Q, 500 * ONE_Q, MAX64, MAX64));
        // Zero pool liquidity inside the range adds no fee.
        sample_q.push_back(make_sample(0, 2 * ONE_Q, 0, 1000 * ONE_Q, 2 * ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 2 * ONE_Q, 1, MAX64, 2 * ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 2 * ONE_Q, MAX64, MAX64, 0, 0));
        // Path starts below and above the range take the one-sided liquidity.
        sample_q.push_back(make_sample(1, ONE_Q / 2, 10 * ONE_Q, 100 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 2 * ONE_Q, 10 * ONE_Q, 100 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(1, 9 * ONE_Q, 10 * ONE_Q, 100 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(0, 2 * ONE_Q, 10 * ONE_Q, 100 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(1, ONE_Q, 10 * ONE_Q, 100 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(1, 4 * ONE_Q, 10 * ONE_Q, 100 * ONE_Q, ONE_Q, ONE_Q));
        sample_q.push_back(make_sample(1, ONE_Q + 1, MAX64, MAX64, MAX64, 0));
        sample_q.push_back(make_sample(0, 4 * ONE_Q - 1, 0, 0, 0, MAX64));
        wait_drained();

        // Range written mid-path: the roots change but the liquidity holds.
        set_position(2 * ONE_Q, 3 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q, 3000);
        queue_path_samples(6, 0);
        wait_drained();

        // Inverted range, then a full-scale range with an oversized fee rate.
        set_position(5 * ONE_Q, 2 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q, 500000);
        queue_path_samples(15, 1);
        wait_drained();
        set_position(0, MAX64, MAX64, MAX64, 20'hFFFFF);
        queue_path_samples(15, 1);
        wait_drained();
        set_position(0, 0, 0, 0, 0);
        queue_path_samples(10, 1);
        wait_drained();

        // Random settings, mostly a sane range with moderate deposits.
        for (int ph = 0; ph < 10; ph++) begin
            if ($urandom_range(0, 4) == 0) begin
                set_position(any_word(), any_word(), any_word(), any_word(),
                             $urandom_range(0, 20'hFFFFF));
            end else begin
                lo = ({32'd0, $urandom_range(0, 200)} << 32) + {32'd0, $urandom};
                set_position(lo, lo + ({32'd0, $urandom_range(0, 100)} << 32) + {32'd0, $urandom},
                             mid_word(), mid_word(), $urandom_range(0, 1000000));
            end
            if (ph == 9) no_idle = 1;
            queue_path_samples(38, $urandom_range(0, 5) != 0);
            wait_drained();
        end

        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
